/* src/bmp8_pkg.sv */
// shared types and constants for the 8-bit bmp header and palette parser
// no dependencies; imported by the output stage and the top level

package bmp8_pkg;

  // largest palette accepted
  localparam int unsigned MAX_COLORS = 256;
  localparam int unsigned MIN_INFO_SIZE = 40;
  localparam int unsigned REQ_BPP = 8;

  // signature bytes
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // byte positions at which a header field is complete
  localparam logic [5:0] POS_SIG0   = 6'd0;
  localparam logic [5:0] POS_SIG1   = 6'd1;
  localparam logic [5:0] POS_OFFSET = 6'd13;
  localparam logic [5:0] POS_HSIZE  = 6'd17;
  localparam logic [5:0] POS_WIDTH  = 6'd21;
  localparam logic [5:0] POS_HEIGHT = 6'd25;
  localparam logic [5:0] POS_PLANES = 6'd27;
  localparam logic [5:0] POS_BPP    = 6'd29;
  localparam logic [5:0] POS_COMPR  = 6'd33;
  localparam logic [5:0] POS_COLORS = 6'd49;
  localparam logic [5:0] POS_LAST   = 6'd53;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_PALETTE = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NO_BM        = 3'd0;
  localparam logic [2:0] ERR_ZERO_OFFSET  = 3'd1;
  localparam logic [2:0] ERR_SHORT_HEADER = 3'd2;
  localparam logic [2:0] ERR_BAD_DIMS     = 3'd3;
  localparam logic [2:0] ERR_BAD_FORMAT   = 3'd4;
  localparam logic [2:0] ERR_BAD_COLORS   = 3'd5;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_SKIP    = 4'b0100,
    PH_PALETTE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [32:0] row_stride;
    logic [31:0] pixel_offset;
    logic [8:0]  color_count;
    logic [7:0]  entry_index;
    logic [31:0] entry_value;
    logic        last_entry;
  } out_item_t;

endpackage

/* src/bmp8_out_stage.sv */
// result register with valid/stall handshake toward the consumer
// depends on bmp8_pkg for the result type

module bmp8_out_stage
  import bmp8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      can_load,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  // slot is free when empty or being drained this cycle
  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* src/bmp8_header_palette_parser.sv */
// top level of the 8-bit uncompressed bmp header and palette parser
// depends on bmp8_pkg and bmp8_out_stage
//
// The block takes a bmp file one byte per request and accepts one byte every
// cycle while the result register can take a result. The parse step is a
// single registered step, and the one-entry result register refills in the
// same cycle it is drained. A request with first_byte high starts a new parse
// from that byte. Header fields are checked in file order and the first failure
// gives one error result, after which bytes are dropped until the next
// first_byte. A good 54-byte header gives one header result (width, height,
// stride rounded up to 4, pixel offset, color count); the extra info header
// bytes are then skipped and each 4-byte palette entry gives one result, the
// final one flagged with last_entry. Fields that do not belong to a result's
// kind read as zero.

module bmp8_header_palette_parser
  import bmp8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [8:0]  colors_r, colors_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [9:0]  entry_r, entry_nxt;

  // state as seen by this byte, after a possible restart
  phase_t      phase_c;
  logic [5:0]  pos_c;
  logic [31:0] shift_c;
  logic [31:0] offset_c;
  logic [31:0] hsize_c;
  logic [31:0] width_c;
  logic [31:0] height_c;
  logic [8:0]  colors_c;
  logic [31:0] skip_c;
  logic [9:0]  entry_c;

  logic [31:0] shift_in;
  logic [9:0]  entry_inc;
  logic        entry_last;
  logic        emit;
  out_item_t   res;

  logic        accept;
  logic        can_load;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  // restart clears everything and enters header parsing
  always_comb begin
    if (in_data.first_byte) begin
      phase_c  = PH_HEADER;
      pos_c    = '0;
      shift_c  = '0;
      offset_c = '0;
      hsize_c  = '0;
      width_c  = '0;
      height_c = '0;
      colors_c = '0;
      skip_c   = '0;
      entry_c  = '0;
    end else begin
      phase_c  = phase_r;
      pos_c    = pos_r;
      shift_c  = shift_r;
      offset_c = offset_r;
      hsize_c  = hsize_r;
      width_c  = width_r;
      height_c = height_r;
      colors_c = colors_r;
      skip_c   = skip_r;
      entry_c  = entry_r;
    end
  end

  // little-endian assembly: new byte enters at the top
  assign shift_in   = {in_data.data_byte, shift_c[31:8]};
  assign entry_inc  = entry_c + 10'd1;
  assign entry_last = {1'b0, entry_inc} >= {1'b0, 1'b0, colors_c};

  always_comb begin
    phase_nxt  = phase_c;
    pos_nxt    = pos_c;
    shift_nxt  = shift_c;
    offset_nxt = offset_c;
    hsize_nxt  = hsize_c;
    width_nxt  = width_c;
    height_nxt = height_c;
    colors_nxt = colors_c;
    skip_nxt   = skip_c;
    entry_nxt  = entry_c;
    emit       = 1'b0;
    res        = '0;

    case (phase_c)
      PH_HEADER: begin
        shift_nxt = shift_in;
        pos_nxt   = pos_c + 6'd1;
        case (pos_c)
          POS_SIG0: begin
            if (in_data.data_byte != SIG_B) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NO_BM;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_SIG1: begin
            if (in_data.data_byte != SIG_M) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NO_BM;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_OFFSET: begin
            offset_nxt = shift_in;
            if (shift_in == '0) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_ZERO_OFFSET;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_HSIZE: begin
            hsize_nxt = shift_in;
            if (shift_in < 32'(MIN_INFO_SIZE)) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SHORT_HEADER;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_WIDTH: begin
            width_nxt = shift_in;
          end
          POS_HEIGHT: begin
            height_nxt = shift_in;
          end
          POS_PLANES: begin
            if (width_c == '0 || height_c == '0 || shift_in[31:16] != 16'd1) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_DIMS;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_BPP: begin
            if (shift_in[31:16] != 16'(REQ_BPP)) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_FORMAT;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_COMPR: begin
            if (shift_in != '0) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_FORMAT;
              phase_nxt      = PH_WAIT;
            end
          end
          POS_COLORS: begin
            if (shift_in == '0 || shift_in > 32'(MAX_COLORS)) begin
              emit           = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_COLORS;
              phase_nxt      = PH_WAIT;
            end else begin
              colors_nxt = shift_in[8:0];
            end
          end
          POS_LAST: begin
            // header complete: extra info bytes precede the palette
            skip_nxt         = hsize_c - 32'(MIN_INFO_SIZE);
            entry_nxt        = '0;
            pos_nxt          = '0;
            shift_nxt        = '0;
            phase_nxt        = (hsize_c == 32'(MIN_INFO_SIZE)) ? PH_PALETTE : PH_SKIP;
            emit             = 1'b1;
            res.kind         = KIND_HEADER;
            res.image_width  = width_c;
            res.image_height = height_c;
            res.row_stride   = ({1'b0, width_c} + 33'd3) & ~33'd3;
            res.pixel_offset = offset_c;
            res.color_count  = colors_c;
          end
          default: begin
          end
        endcase
      end
      PH_SKIP: begin
        skip_nxt = skip_c - 32'd1;
        if (skip_c == 32'd1) begin
          phase_nxt = PH_PALETTE;
          pos_nxt   = '0;
          shift_nxt = '0;
        end
      end
      PH_PALETTE: begin
        shift_nxt = shift_in;
        pos_nxt   = pos_c + 6'd1;
        // fourth byte of an entry
        if (pos_c >= 6'd3) begin
          emit            = 1'b1;
          res.kind        = KIND_PALETTE;
          res.entry_index = entry_c[7:0];
          res.entry_value = shift_in;
          res.last_entry  = entry_last;
          entry_nxt       = entry_inc;
          pos_nxt         = '0;
          shift_nxt       = '0;
          if (entry_last) begin
            phase_nxt = PH_WAIT;
          end
        end
      end
      default: begin
        // waiting: bytes are dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      pos_r    <= '0;
      shift_r  <= '0;
      offset_r <= '0;
      hsize_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      colors_r <= '0;
      skip_r   <= '0;
      entry_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      offset_r <= offset_nxt;
      hsize_r  <= hsize_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      colors_r <= colors_nxt;
      skip_r   <= skip_nxt;
      entry_r  <= entry_nxt;
    end
  end

  // result register, refilled in the cycle it drains
  bmp8_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && emit),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
